>>> hw/rtl/rsbb_pkg.sv
package rsbb_pkg;

    localparam int CHAN_W             = 8;
    localparam int RADIUS_W           = 5;
    localparam int MAX_RADIUS_DEF     = 31;
    localparam int MAX_ROW_PIXELS_DEF = 4096;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
        logic              row_end;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              row_last;
        logic              run_last;
    } t_pix_out;

    typedef struct packed {
        logic row_last;
        logic run_last;
    } t_flags;

    typedef struct packed {
        logic step;
        logic fill;
    } t_cell_ctrl;

    // Bits of a window sum: up to 255 times the widest window.
    function automatic int sum_width(input int max_radius);
        return $clog2(255 * (2 * max_radius + 1) + 1);
    endfunction

    // Radius index width.
    function automatic int radius_width(input int max_radius);
        return $clog2(max_radius + 1);
    endfunction

    // Fraction bits of the reciprocal: exact floor for every sum of any window.
    function automatic int recip_shift(input int max_radius);
        return sum_width(max_radius) + radius_width(max_radius) + 1;
    endfunction

endpackage

>>> hw/rtl/rsbb_cell.sv
module rsbb_cell (
    input  logic                i_clk,
    input  rsbb_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_entry,
    input  rsbb_pkg::t_rgb      i_pix,
    input  rsbb_pkg::t_rgb      i_left,
    output rsbb_pkg::t_rgb      o_pix
);
    import rsbb_pkg::*;

    t_rgb r_pix;

    // Load the new pixel at the entry point or on a row fill, else take the neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            if (i_ctrl.fill || i_entry) begin
                r_pix <= i_pix;
            end else begin
                r_pix <= i_left;
            end
        end
    end

    assign o_pix = r_pix;

endmodule

>>> hw/rtl/rsbb_scale.sv
module rsbb_scale #(
    parameter int MAX_RADIUS = rsbb_pkg::MAX_RADIUS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  logic [rsbb_pkg::sum_width(MAX_RADIUS)-1:0]   i_sum_r,
    input  logic [rsbb_pkg::sum_width(MAX_RADIUS)-1:0]   i_sum_g,
    input  logic [rsbb_pkg::sum_width(MAX_RADIUS)-1:0]   i_sum_b,
    input  logic [rsbb_pkg::recip_shift(MAX_RADIUS):0]   i_recip,
    input  rsbb_pkg::t_flags                             i_flags,
    output logic                                         o_ready,
    output logic                                         o_valid,
    output rsbb_pkg::t_pix_out                           o_data,
    input  logic                                         i_stall
);
    import rsbb_pkg::*;

    localparam int SUM_W  = sum_width(MAX_RADIUS);
    localparam int SHIFT  = recip_shift(MAX_RADIUS);
    localparam int RCW    = SHIFT + 1;
    localparam int PROD_W = SUM_W + RCW;

    logic              r_v2;
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    t_flags            r_flags2;
    logic              r_ov;
    t_pix_out          r_out;
    logic              w_out_ready;

    assign w_out_ready = !r_ov || !i_stall;
    assign o_ready     = !r_v2 || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (w_out_ready) begin
                r_ov <= r_v2;
            end
        end
    end

    // Multiply by the rounded-up reciprocal of the window length.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod_r <= PROD_W'(i_sum_r) * PROD_W'(i_recip);
            r_prod_g <= PROD_W'(i_sum_g) * PROD_W'(i_recip);
            r_prod_b <= PROD_W'(i_sum_b) * PROD_W'(i_recip);
            r_flags2 <= i_flags;
        end
        if (w_out_ready && r_v2) begin
            r_out.red_out   <= r_prod_r[SHIFT +: CHAN_W];
            r_out.green_out <= r_prod_g[SHIFT +: CHAN_W];
            r_out.blue_out  <= r_prod_b[SHIFT +: CHAN_W];
            r_out.row_last  <= r_flags2.row_last;
            r_out.run_last  <= r_flags2.run_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/running_sum_box_blur_row.sv
// Horizontal box blur of one image row with clamp-to-edge at both ends.
// Input channel (i_valid / o_stall, payload i_data): one RGB pixel per item,
//   row_end set on the last pixel of a row. Output channel (o_valid / i_stall,
//   payload o_data): one averaged pixel per item, row_last on the final pixel
//   of a row, run_last on the last item caused by a given input item.
// Configuration: i_cfg_we writes i_cfg_wdata into the radius register. The
//   radius is sampled at the first pixel of each row and saturated to
//   MAX_RADIUS; the window is 2*radius+1 pixels.
// Throughput: one pixel per cycle inside a row while the receiver does not stall.
//   The row-end pixel is followed by radius flush steps that feed the last pixel
//   again, during which o_stall stays high.
// Pipeline: an output passes the window step, the reciprocal multiply and the
//   output register, each registered. Output k of a row appears once input
//   k+radius has been taken.
// The window is a chain of pixel cells; the running sums add the entering
//   pixel and drop the one leaving the chain's far end.
// Reset: radius returns to 1, the pipeline empties, the next pixel starts a
//   row. No clearing pass is needed: the first pixel fills every cell.
// Receiver stall: each stage holds its item and stalls the one before; the
//   input is stalled only once the window stage itself cannot advance.
module running_sum_box_blur_row #(
    parameter int MAX_RADIUS     = rsbb_pkg::MAX_RADIUS_DEF,
    parameter int MAX_ROW_PIXELS = rsbb_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsbb_pkg::RADIUS_W-1:0]   i_cfg_wdata,
    input  logic                            i_valid,
    input  rsbb_pkg::t_pix_in               i_data,
    output logic                            o_stall,
    output logic                            o_valid,
    output rsbb_pkg::t_pix_out              o_data,
    input  logic                            i_stall
);
    import rsbb_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int SUM_W = sum_width(MAX_RADIUS);
    localparam int RW    = radius_width(MAX_RADIUS);
    localparam int LW    = RW + 1;
    localparam int SHIFT = recip_shift(MAX_RADIUS);
    localparam int RCW   = SHIFT + 1;
    localparam int PW    = $clog2(MAX_ROW_PIXELS);

    localparam logic [PW-1:0] LAST_POS = PW'(MAX_ROW_PIXELS - 1);

    // Control state
    logic [RADIUS_W-1:0] r_radius;
    logic [RW-1:0]       r_row_radius;
    logic [RW-1:0]       r_lead;
    logic [RW-1:0]       r_flush_cnt;
    logic [PW-1:0]       r_pos;
    logic                r_e1;

    // Window stage payload
    t_rgb                r_last_pix;
    logic [SUM_W-1:0]    r_sum_r, r_sum_g, r_sum_b;
    logic [RCW-1:0]      r_recip1;
    t_flags              r_flags1;

    logic [SUM_W-1:0]    n_sum_r, n_sum_g, n_sum_b;
    logic [RW-1:0]       n_lead;

    logic                w_s2_ready;
    logic                w_step_ok;
    logic                w_flushing;
    logic                w_accept;
    logic                w_fstep;
    logic                w_step;
    logic                w_first;
    logic                w_end;
    logic                w_emit;
    logic [RW-1:0]       w_radius_sat;
    logic [RW-1:0]       w_r;
    logic [RW-1:0]       w_lead_cur;
    logic [LW-1:0]       w_len;
    t_rgb                w_pix;
    t_rgb                w_tap;
    t_flags              w_flags;
    t_cell_ctrl          w_ctrl;
    logic [RCW-1:0]      w_recip_tab [0:MAX_RADIUS];
    t_rgb                w_cells [0:DEPTH-1];

    // Reciprocal table: ceil(2^SHIFT / (2g+1)) for each radius g.
    for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
        localparam longint unsigned RECIP =
            ((64'd1 << SHIFT) + 64'(2 * g)) / 64'(2 * g + 1);
        assign w_recip_tab[g] = RCW'(RECIP);
    end

    assign w_radius_sat = (int'(r_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(r_radius);

    // Handshake: the window stage steps when its output slot is free or drains.
    assign w_step_ok  = !r_e1 || w_s2_ready;
    assign w_flushing = (r_flush_cnt != '0);
    assign o_stall    = w_flushing || !w_step_ok;
    assign w_accept   = i_valid && !o_stall;
    assign w_fstep    = w_flushing && w_step_ok;
    assign w_step     = w_accept || w_fstep;

    assign w_first = w_accept && (r_pos == '0);
    assign w_end   = i_data.row_end || (r_pos == LAST_POS);
    assign w_r     = w_first ? w_radius_sat : r_row_radius;
    assign w_len   = {w_r, 1'b1};

    // Flush steps replay the last pixel of the row.
    always_comb begin
        if (w_accept) begin
            w_pix.red   = i_data.red_in;
            w_pix.green = i_data.green_in;
            w_pix.blue  = i_data.blue_in;
        end else begin
            w_pix = r_last_pix;
        end
    end

    // Output k is due once padded position k+radius is in the window.
    assign w_lead_cur = w_first ? w_radius_sat : r_lead;
    assign w_emit     = (w_lead_cur == '0);
    assign n_lead     = w_emit ? '0 : w_lead_cur - RW'(1);

    assign w_flags.row_last = (w_fstep && (r_flush_cnt == RW'(1)))
                            || (w_accept && w_end && (w_r == '0));
    assign w_flags.run_last = w_flags.row_last || (w_accept && !w_end);

    // Running sums: first pixel fills the whole window, later steps slide it.
    always_comb begin
        if (w_first) begin
            n_sum_r = SUM_W'(w_len) * SUM_W'(w_pix.red);
            n_sum_g = SUM_W'(w_len) * SUM_W'(w_pix.green);
            n_sum_b = SUM_W'(w_len) * SUM_W'(w_pix.blue);
        end else begin
            n_sum_r = r_sum_r + SUM_W'(w_pix.red)   - SUM_W'(w_tap.red);
            n_sum_g = r_sum_g + SUM_W'(w_pix.green) - SUM_W'(w_tap.green);
            n_sum_b = r_sum_b + SUM_W'(w_pix.blue)  - SUM_W'(w_tap.blue);
        end
    end

    // Chain of window cells; a pixel enters 2*radius+1 cells from the far end.
    assign w_ctrl.step = w_step;
    assign w_ctrl.fill = w_first;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam bit EVEN = ((DEPTH - 1 - i) % 2) == 0;
        localparam int ERAD = (DEPTH - 1 - i) / 2;
        logic w_entry;
        t_rgb w_left;

        assign w_entry = EVEN && (r_row_radius == RW'(ERAD));

        if (i == 0) begin : g_head
            assign w_left = w_pix;
        end else begin : g_body
            assign w_left = w_cells[i-1];
        end

        rsbb_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_entry (w_entry),
            .i_pix   (w_pix),
            .i_left  (w_left),
            .o_pix   (w_cells[i])
        );
    end

    assign w_tap = w_cells[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RESET;
            r_row_radius <= '0;
            r_lead       <= '0;
            r_flush_cnt  <= '0;
            r_pos        <= '0;
            r_e1         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (w_first) begin
                r_row_radius <= w_radius_sat;
            end
            if (w_step) begin
                r_lead <= n_lead;
                r_e1   <= w_emit;
            end else if (w_s2_ready) begin
                r_e1 <= 1'b0;
            end
            if (w_accept) begin
                // Close the row on its flag or at the row length limit.
                if (w_end) begin
                    r_pos       <= '0;
                    r_flush_cnt <= w_r;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end else if (w_fstep) begin
                r_flush_cnt <= r_flush_cnt - RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last_pix <= w_pix;
        end
        if (w_step) begin
            r_sum_r  <= n_sum_r;
            r_sum_g  <= n_sum_g;
            r_sum_b  <= n_sum_b;
            r_recip1 <= w_recip_tab[w_r];
            r_flags1 <= w_flags;
        end
    end

    rsbb_scale #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e1),
        .i_sum_r (r_sum_r),
        .i_sum_g (r_sum_g),
        .i_sum_b (r_sum_b),
        .i_recip (r_recip1),
        .i_flags (r_flags1),
        .o_ready (w_s2_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

>>> bench/running_sum_box_blur_row_tb.sv
module running_sum_box_blur_row_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsbb_pkg::*;

    localparam int WIN_DEPTH     = 2 * MAX_RADIUS_DEF + 1;
    // Window step, reciprocal multiply and output register, plus the row-end flush.
    localparam int SETTLE_CYCLES = MAX_RADIUS_DEF + 16;

    // Track the row the block is blurring and hold the output items it still owes.
    class blur_row_tracker;
        logic [RADIUS_W-1:0] radius;
        logic [RADIUS_W-1:0] row_radius;
        t_rgb                window[WIN_DEPTH];
        t_rgb                first_pixel;
        int                  pixels_seen;
        int                  outputs_sent;
        t_pix_out            owed[$];
        int                  pixels_taken;
        int                  rows_done;
        int                  checked;
        int                  mismatches;

        function new();
            radius       = RADIUS_RESET;
            row_radius   = '0;
            first_pixel  = '0;
            pixels_seen  = 0;
            outputs_sent = 0;
            pixels_taken = 0;
            rows_done    = 0;
            checked      = 0;
            mismatches   = 0;
            foreach (window[i]) window[i] = '0;
        endfunction

        function void write_radius(input logic [RADIUS_W-1:0] value);
            radius = value;
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        // Floor mean of positions k-r..k+r, clamped to the first and the newest pixel.
        function t_pix_out window_mean(input int k, input int newest,
                                       input logic row_tail, input logic run_tail);
            int       r;
            int       rs;
            int       gs;
            int       bs;
            int       j;
            int       pos;
            t_rgb     p;
            t_pix_out res;
            r  = int'(row_radius);
            rs = 0;
            gs = 0;
            bs = 0;
            for (j = k - r; j <= k + r; j++) begin
                pos = (j > newest) ? newest : j;
                p   = (pos <= 0) ? first_pixel : window[pos % WIN_DEPTH];
                rs += p.red;
                gs += p.green;
                bs += p.blue;
            end
            res.red_out   = CHAN_W'(rs / (2 * r + 1));
            res.green_out = CHAN_W'(gs / (2 * r + 1));
            res.blue_out  = CHAN_W'(bs / (2 * r + 1));
            res.row_last  = row_tail;
            res.run_last  = run_tail;
            return res;
        endfunction

        function void take_pixel(input t_pix_in d);
            int   pos;
            logic closing;
            t_rgb pix;
            pix.red   = d.red_in;
            pix.green = d.green_in;
            pix.blue  = d.blue_in;
            closing   = d.row_end;
            pos       = pixels_seen;
            pixels_taken++;
            // Latch the radius and the left edge on the first pixel of a row.
            if (pixels_seen == 0) begin
                row_radius   = radius;
                first_pixel  = pix;
                outputs_sent = 0;
            end
            window[pos % WIN_DEPTH] = pix;
            pixels_seen++;
            // A row that runs to full length closes by itself.
            if (pixels_seen >= MAX_ROW_PIXELS_DEF)
                closing = 1'b1;
            if (!closing) begin
                if (pos >= int'(row_radius)) begin
                    owed.push_back(window_mean(outputs_sent, pos, 1'b0, 1'b1));
                    outputs_sent++;
                end
            end else begin
                while (outputs_sent <= pos) begin
                    owed.push_back(window_mean(outputs_sent, pos, outputs_sent == pos,
                                               outputs_sent == pos));
                    outputs_sent++;
                end
                pixels_seen  = 0;
                outputs_sent = 0;
                rows_done++;
            end
        endfunction

        function void match_output(input t_pix_out got);
            t_pix_out want;
            if (owed.size() == 0) begin
                $error("output item with nothing owed: red %0d green %0d blue %0d",
                       got.red_out, got.green_out, got.blue_out);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got.red_out !== want.red_out) begin
                $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                mismatches++;
            end
            if (got.green_out !== want.green_out) begin
                $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                mismatches++;
            end
            if (got.blue_out !== want.blue_out) begin
                $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                mismatches++;
            end
            if (got.row_last !== want.row_last) begin
                $error("row_last: expected %0d, got %0d", want.row_last, got.row_last);
                mismatches++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0d, got %0d", want.run_last, got.run_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [RADIUS_W-1:0] i_cfg_wdata = '0;
    logic                i_valid     = 1'b0;
    t_pix_in             i_data      = '0;
    logic                o_stall;
    logic                o_valid;
    t_pix_out            o_data;
    logic                i_stall     = 1'b0;

    blur_row_tracker tracker = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int radius_writes = 0;

    running_sum_box_blur_row u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the output side at random; one assignment per edge.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Sample both handshakes at the edge: values seen here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            tracker.take_pixel(i_data);
        if (i_rst_n && o_valid && !i_stall)
            tracker.match_output(o_data);
    end

    // Pick a channel value, leaning on the extremes now and then.
    function automatic logic [CHAN_W-1:0] rand_channel();
        if ($urandom_range(5) == 0)
            return $urandom_range(1) ? {CHAN_W{1'b1}} : {CHAN_W{1'b0}};
        return CHAN_W'($urandom_range(255));
    endfunction

    // Offer one pixel item and hold it until the block takes it. Leave valid high on
    // return so that a following item goes out back to back.
    task automatic push_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic row_end);
        t_pix_in d;
        d.red_in   = r;
        d.green_in = g;
        d.blue_in  = b;
        d.row_end  = row_end;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid, wait for every owed item, then let the pipeline and any flush drain.
    task automatic settle();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tracker.owed_count() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the radius only with the block idle.
    task automatic set_radius(input logic [RADIUS_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.write_radius(value);
        i_cfg_we <= 1'b0;
        radius_writes++;
    endtask

    // Stream random rows until the item budget is used up, changing radius between rows.
    task automatic blur_rows(input int budget);
        int sent;
        int len;
        int n;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(4) == 0)
                set_radius(($urandom_range(2) == 0) ?
                           ($urandom_range(1) ? RADIUS_W'(MAX_RADIUS_DEF) : RADIUS_W'(0)) :
                           RADIUS_W'($urandom_range(MAX_RADIUS_DEF)));
            // Mostly short rows; some longer than the widest window.
            len = ($urandom_range(7) == 0) ? $urandom_range(64, 90) : $urandom_range(1, 24);
            // Trim the last row to the budget.
            if (len > budget - sent)
                len = budget - sent;
            for (n = 1; n <= len; n++)
                push_pixel(rand_channel(), rand_channel(), rand_channel(), n == len);
            sent += len;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset radius of 1: a one-pixel row, then a two-pixel row at the extremes.
        push_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        // Radius 0 passes pixels straight through.
        set_radius(RADIUS_W'(0));
        push_pixel(8'h01, 8'h80, 8'hFE, 1'b0);
        push_pixel(8'h7F, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'h55, 8'hAA, 1'b1);

        // Widest window over a row far shorter than it; all-ones gives the largest sums.
        set_radius(RADIUS_W'(MAX_RADIUS_DEF));
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

        // Change the radius in the middle of a row: the row keeps radius 2,
        // the next row picks up 5. The write also makes the sender wait for
        // every owed item with the row still open.
        set_radius(RADIUS_W'(2));
        push_pixel(8'h10, 8'h20, 8'h30, 1'b0);
        push_pixel(8'hF0, 8'hE0, 8'hD0, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        set_radius(RADIUS_W'(5));
        push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h33, 8'hCC, 8'h99, 1'b0);
        push_pixel(8'h80, 8'h40, 8'h20, 1'b1);
        push_pixel(8'h01, 8'h02, 8'h03, 1'b0);
        push_pixel(8'hFD, 8'hFE, 8'hFF, 1'b1);

        // Random rows under three idling mixes.
        send_idle_pct = 29;
        recv_idle_pct = 68;
        blur_rows(131);
        send_idle_pct = 68;
        recv_idle_pct = 29;
        blur_rows(131);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        blur_rows(130);

        settle();
        if (tracker.owed_count() != 0) begin
            $error("%0d output items never arrived", tracker.owed_count());
            tracker.mismatches++;
        end

        $display("covered %0d pixels in %0d rows, %0d output items checked",
                 tracker.pixels_taken, tracker.rows_done, tracker.checked);
        $display("radius written %0d times, incl. 0, 31 and a write inside an open row",
                 radius_writes);
        if (tracker.mismatches == 0)
            $display("running_sum_box_blur_row regression: pass");
        else
            $display("running_sum_box_blur_row regression: fail");
        $finish;
    end

    // Watchdog: end a hung run well past the slowest correct one.
    initial begin
        #1_000_000;
        $display("running_sum_box_blur_row regression: fail");
        $finish;
    end

endmodule
